[hdl/ltc_pkg.sv]
`default_nettype none

package ltc_pkg;

  localparam int CharW    = 8;
  localparam int CodeW    = 3;
  localparam int NumClass = 6;

  localparam int MAX_LEN_DEF = 128;
  localparam int GUID_LEN    = 36;
  localparam int BIN_MIN_LEN = 3;
  localparam int GUID_DASH0  = 8;
  localparam int GUID_DASH1  = 13;
  localparam int GUID_DASH2  = 18;
  localparam int GUID_DASH3  = 23;

  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_ONE   = 8'h31;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;
  localparam logic [CharW-1:0] CH_B     = 8'h62;
  localparam logic [CharW-1:0] CH_DASH  = 8'h2d;
  localparam logic [CharW-1:0] CH_DOT   = 8'h2e;
  localparam logic [CharW-1:0] CH_LO_A  = 8'h61;
  localparam logic [CharW-1:0] CH_LO_F  = 8'h66;
  localparam logic [CharW-1:0] CH_UP_A  = 8'h41;
  localparam logic [CharW-1:0] CH_UP_F  = 8'h46;

  typedef enum logic [CodeW-1:0] {
    CL_POSINT  = 3'd0,
    CL_NEGINT  = 3'd1,
    CL_BINARY  = 3'd2,
    CL_GUID    = 3'd3,
    CL_POSFLT  = 3'd4,
    CL_NEGFLT  = 3'd5,
    CL_UNKNOWN = 3'd6
  } class_t;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } char_t;

  typedef struct packed {
    class_t class_code;
    logic   too_long;
  } result_t;

  function automatic logic is_dig(logic [CharW-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(logic [CharW-1:0] c);
    return is_dig(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

endpackage

`default_nettype wire

[hdl/ltc_char_if.sv]
`default_nettype none

interface ltc_char_if;
  import ltc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] ch;
  logic             last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

[hdl/ltc_class_if.sv]
`default_nettype none

interface ltc_class_if;
  import ltc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CodeW-1:0] class_code;
  logic             too_long;

  modport source (output valid, output class_code, output too_long, input ready);
  modport sink (input valid, input class_code, input too_long, output ready);
endinterface

`default_nettype wire

[hdl/ltc_scan.sv]
`default_nettype none

module ltc_scan #(
  parameter int MAX_LEN = ltc_pkg::MAX_LEN_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire ltc_pkg::char_t  item,
  output ltc_pkg::result_t     result
);
  import ltc_pkg::*;

  localparam int PosW = $clog2(MAX_LEN + 1);

  logic [PosW-1:0]     char_position, char_position_next;
  logic [NumClass-1:0] class_alive, class_alive_next;
  logic [1:0]          dot_count, dot_count_next;
  logic                prev_was_dot, prev_was_dot_next;
  logic                digit_seen, digit_seen_next;
  logic                overflowed, overflowed_next;
  logic                flt_ok;

  // classes that can still hold after character c at position p
  function automatic logic [NumClass-1:0] survivors(logic [CharW-1:0] c,
                                                    logic [PosW-1:0] p);
    logic [NumClass-1:0] keep;
    logic d, dash, dot, at0, at1, guid_dash;
    keep = '0;
    d    = is_dig(c);
    dash = (c == CH_DASH);
    dot  = (c == CH_DOT);
    at0  = (p == '0);
    at1  = (p == PosW'(1));
    guid_dash = (p == PosW'(GUID_DASH0)) || (p == PosW'(GUID_DASH1)) ||
                (p == PosW'(GUID_DASH2)) || (p == PosW'(GUID_DASH3));
    keep[CL_POSINT] = d;
    keep[CL_NEGINT] = at0 ? dash : d;
    keep[CL_BINARY] = at0 ? (c == CH_ZERO) :
                      at1 ? (c == CH_B) : ((c == CH_ZERO) || (c == CH_ONE));
    keep[CL_GUID]   = (p < PosW'(GUID_LEN)) &&
                      (guid_dash ? dash : (is_hex(c) || dash));
    keep[CL_POSFLT] = at0 ? d : (d || dot);
    keep[CL_NEGFLT] = at0 ? dash : at1 ? d : (d || dot);
    return keep;
  endfunction

  always_comb begin
    char_position_next = char_position;
    class_alive_next   = class_alive;
    dot_count_next     = dot_count;
    prev_was_dot_next  = prev_was_dot;
    digit_seen_next    = digit_seen;
    overflowed_next    = overflowed;
    if (char_position >= PosW'(MAX_LEN)) begin
      overflowed_next = 1'b1;
    end else begin
      class_alive_next = class_alive & survivors(item.ch, char_position);
      if ((item.ch == CH_DOT) && (dot_count < 2'd2)) begin
        dot_count_next = dot_count + 2'd1;
      end
      prev_was_dot_next  = (item.ch == CH_DOT);
      digit_seen_next    = digit_seen | is_dig(item.ch);
      char_position_next = char_position + PosW'(1);
    end
  end

  // priority decision on the state as it stands after this character
  always_comb begin
    flt_ok = (dot_count_next == 2'd1) && !prev_was_dot_next;
    result.class_code = CL_UNKNOWN;
    result.too_long   = overflowed_next;
    if (!overflowed_next) begin
      if (class_alive_next[CL_POSINT]) begin
        result.class_code = CL_POSINT;
      end else if (class_alive_next[CL_NEGINT] && digit_seen_next) begin
        result.class_code = CL_NEGINT;
      end else if (class_alive_next[CL_BINARY] &&
                   (char_position_next >= PosW'(BIN_MIN_LEN))) begin
        result.class_code = CL_BINARY;
      end else if (class_alive_next[CL_GUID] &&
                   (char_position_next == PosW'(GUID_LEN))) begin
        result.class_code = CL_GUID;
      end else if (class_alive_next[CL_POSFLT] && flt_ok) begin
        result.class_code = CL_POSFLT;
      end else if (class_alive_next[CL_NEGFLT] && flt_ok) begin
        result.class_code = CL_NEGFLT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      char_position <= '0;
      class_alive   <= '1;
      dot_count     <= '0;
      prev_was_dot  <= 1'b0;
      digit_seen    <= 1'b0;
      overflowed    <= 1'b0;
    end else if (step) begin
      char_position <= char_position_next;
      class_alive   <= class_alive_next;
      dot_count     <= dot_count_next;
      prev_was_dot  <= prev_was_dot_next;
      digit_seen    <= digit_seen_next;
      overflowed    <= overflowed_next;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    char_position <= PosW'(MAX_LEN))
    else $error("position counter beyond limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && item.last |=> (char_position == '0) && (class_alive == '1))
    else $error("token state not cleared after last item");

  a_overflow_pos: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> (char_position == PosW'(MAX_LEN)))
    else $error("overflow flag without full position count");

  a_long_unknown: assert property (@(posedge clk) disable iff (rst)
    result.too_long |-> (result.class_code == CL_UNKNOWN))
    else $error("overlong token given a class");

endmodule

`default_nettype wire

[hdl/lexical_token_classifier_unit.sv]
// Lexical token classifier.
// chars (sink): one character per item, last marks the final character of
// a token. classes (source): one item per token, carrying class_code
// (0 posint, 1 negint, 2 binary, 3 guid, 4 posfloat, 5 negfloat,
// 6 unidentified) and too_long, set when the token ran past MAX_LEN
// characters (its class is then 6).
// Throughput: one character per cycle while classes takes its results,
// including the last character of one token followed directly by the first
// of the next. A result item passes from the input register, which holds
// its last character, through the class update logic into the result
// register, which loads it once it has room.
// When classes stalls, a waiting result holds in the result register; one
// more token's characters enter, and chars.ready drops only when the input
// register holds a last character whose result has nowhere to go.
// Reset (synchronous, rst high) empties both registers and returns the
// token state to the start of a token.
`default_nettype none

module lexical_token_classifier_unit #(
  parameter int MAX_LEN = ltc_pkg::MAX_LEN_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  ltc_char_if.sink     chars,
  ltc_class_if.source  classes
);
  import ltc_pkg::*;

  logic    s1_valid;
  char_t   s1_item;
  logic    out_valid;
  result_t out_data;
  result_t scan_result;
  logic    out_free;
  logic    consume;

  assign out_free = !out_valid || classes.ready;
  // a non-final character needs no result slot
  assign consume  = s1_valid && (!s1_item.last || out_free);
  assign chars.ready = !s1_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_item.ch   <= chars.ch;
      s1_item.last <= chars.last;
    end
  end

  ltc_scan #(
    .MAX_LEN (MAX_LEN)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (consume),
    .item   (s1_item),
    .result (scan_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= consume && s1_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && s1_item.last) begin
      out_data <= scan_result;
    end
  end

  assign classes.valid      = out_valid;
  assign classes.class_code = out_data.class_code;
  assign classes.too_long   = out_data.too_long;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    consume && s1_item.last |=> out_valid)
    else $error("final character gave no result item");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> chars.ready)
    else $error("input held off with empty input register");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !consume |=> s1_valid && $stable(s1_item))
    else $error("waiting character lost");

endmodule

`default_nettype wire

[tb/sv/lexical_token_classifier_unit_test.sv]
`timescale 1ns / 100ps

module lexical_token_classifier_unit_test;
  import ltc_pkg::*;

  localparam int TOK_MAX      = MAX_LEN_DEF;
  localparam int RAND_CHARS   = 1300;
  localparam int QUIET_FROM   = 400;
  localparam int QUIET_TO     = 800;
  localparam int HOLD_AT      = 1000;
  localparam int HOLD_CYCLES  = 120;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT     = 21;

  typedef struct {
    string      text;
    logic [7:0] fill_ch;
    int         fill_n;
    bit         typed;
    class_t     code;
    logic       too_long;
  } tok_row_t;

  logic clk = 1'b0;
  logic rst;

  ltc_char_if  chars_bus ();
  ltc_class_if class_bus ();

  lexical_token_classifier_unit #(
    .MAX_LEN(TOK_MAX)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_bus),
    .classes(class_bus)
  );

  always #1 clk = ~clk;

  // tokens: literal text followed by fill_n copies of fill_ch
  tok_row_t dir_tab [25] = '{
    '{"0", 8'h00, 0, 1'b1, CL_POSINT, 1'b0},
    '{"9876543210", 8'h00, 0, 1'b0, CL_POSINT, 1'b0},
    '{"-", 8'h00, 0, 1'b1, CL_UNKNOWN, 1'b0},
    '{"-7", 8'h00, 0, 1'b1, CL_NEGINT, 1'b0},
    '{"-0123", 8'h00, 0, 1'b0, CL_NEGINT, 1'b0},
    '{"0b1", 8'h00, 0, 1'b1, CL_BINARY, 1'b0},
    '{"0b", 8'h00, 0, 1'b0, CL_UNKNOWN, 1'b0},
    '{"0b0110", 8'h00, 0, 1'b0, CL_BINARY, 1'b0},
    '{"0b012", 8'h00, 0, 1'b0, CL_UNKNOWN, 1'b0},
    '{"123e4567-e89b-12d3-a456-426614174000", 8'h00, 0, 1'b1, CL_GUID, 1'b0},
    '{"ABCDEF01-2345-6789-abcd-EF0123456789", 8'h00, 0, 1'b0, CL_GUID, 1'b0},
    '{"123e45678e89b-12d3-a456-426614174000", 8'h00, 0, 1'b0, CL_UNKNOWN, 1'b0},
    '{"", CH_DASH, GUID_LEN, 1'b0, CL_GUID, 1'b0},
    '{"3.14", 8'h00, 0, 1'b1, CL_POSFLT, 1'b0},
    '{"-0.5", 8'h00, 0, 1'b1, CL_NEGFLT, 1'b0},
    '{".5", 8'h00, 0, 1'b0, CL_UNKNOWN, 1'b0},
    '{"5.", 8'h00, 0, 1'b0, CL_UNKNOWN, 1'b0},
    '{"1.2.3", 8'h00, 0, 1'b0, CL_UNKNOWN, 1'b0},
    '{"-.5", 8'h00, 0, 1'b0, CL_UNKNOWN, 1'b0},
    '{"0.0", 8'h00, 0, 1'b0, CL_POSFLT, 1'b0},
    '{"fab", 8'h00, 0, 1'b0, CL_UNKNOWN, 1'b0},
    '{"", 8'h00, 1, 1'b1, CL_UNKNOWN, 1'b0},
    '{"", 8'hff, 2, 1'b0, CL_UNKNOWN, 1'b0},
    '{"", CH_NINE, TOK_MAX, 1'b1, CL_POSINT, 1'b0},
    '{"", CH_ONE, TOK_MAX + 1, 1'b1, CL_UNKNOWN, 1'b1}
  };

  // running token state of the predictor
  int unsigned         tok_pos     = 0;
  logic [NumClass-1:0] tok_alive   = '1;
  int                  tok_dots    = 0;
  logic                tok_dot_end = 1'b0;
  logic                tok_digit   = 1'b0;
  logic                tok_over    = 1'b0;

  result_t    class_q [$];
  logic [7:0] tok_buf [$];
  bit         typed_on = 1'b0;
  result_t    typed_res;
  int         chars_sent = 0;
  int         errs = 0;
  int         stall_cycles = 0;
  logic       quiet = 1'b0;
  logic       hold_go = 1'b0;

  function automatic void token_classify(input logic [7:0] c, input logic fin,
                                         output logic emit, output result_t res);
    logic [NumClass-1:0] keep;
    logic                dig, dash, dot, hex, dash_slot, flt_ok;
    dig  = (c >= CH_ZERO) && (c <= CH_NINE);
    dash = (c == CH_DASH);
    dot  = (c == CH_DOT);
    // folding to lower case maps only 'A'..'F' onto 'a'..'f'
    hex  = dig || (((c | 8'h20) >= CH_LO_A) && ((c | 8'h20) <= CH_LO_F));
    emit = 1'b0;
    res.class_code = CL_UNKNOWN;
    res.too_long = 1'b0;
    if (tok_pos >= TOK_MAX) begin
      tok_over = 1'b1;
    end else begin
      dash_slot = (tok_pos == GUID_DASH0) || (tok_pos == GUID_DASH1) ||
                  (tok_pos == GUID_DASH2) || (tok_pos == GUID_DASH3);
      keep = '0;
      keep[CL_POSINT] = dig;
      keep[CL_NEGINT] = (tok_pos == 0) ? dash : dig;
      keep[CL_BINARY] = (tok_pos == 0) ? (c == CH_ZERO) :
                        (tok_pos == 1) ? (c == CH_B) : ((c == CH_ZERO) || (c == CH_ONE));
      keep[CL_GUID]   = (tok_pos < GUID_LEN) && (dash_slot ? dash : (hex || dash));
      keep[CL_POSFLT] = (tok_pos == 0) ? dig : (dig || dot);
      keep[CL_NEGFLT] = (tok_pos == 0) ? dash : (tok_pos == 1) ? dig : (dig || dot);
      tok_alive &= keep;
      if (dot && tok_dots < 2) tok_dots++;
      tok_dot_end = dot;
      if (dig) tok_digit = 1'b1;
      tok_pos++;
    end
    if (fin) begin
      emit = 1'b1;
      res.too_long = tok_over;
      if (!tok_over) begin
        flt_ok = (tok_dots == 1) && !tok_dot_end;
        if (tok_alive[CL_POSINT]) res.class_code = CL_POSINT;
        else if (tok_alive[CL_NEGINT] && tok_digit) res.class_code = CL_NEGINT;
        else if (tok_alive[CL_BINARY] && tok_pos >= BIN_MIN_LEN) res.class_code = CL_BINARY;
        else if (tok_alive[CL_GUID] && tok_pos == GUID_LEN) res.class_code = CL_GUID;
        else if (tok_alive[CL_POSFLT] && flt_ok) res.class_code = CL_POSFLT;
        else if (tok_alive[CL_NEGFLT] && flt_ok) res.class_code = CL_NEGFLT;
      end
      tok_pos     = 0;
      tok_alive   = '1;
      tok_dots    = 0;
      tok_dot_end = 1'b0;
      tok_digit   = 1'b0;
      tok_over    = 1'b0;
    end
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CH_ZERO + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'(CH_ZERO + v);
    return 8'(($urandom_range(1) ? CH_UP_A : CH_LO_A) + v - 10);
  endfunction

  // characters that sit near the class boundaries, plus any byte at all
  function automatic logic [7:0] odd_char();
    case ($urandom_range(7))
      0: return CH_DASH;
      1: return CH_DOT;
      2: return CH_B;
      3: return CH_ZERO;
      4: return CH_ONE;
      5: return CH_UP_F;
      6: return rand_digit();
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void add_digits(input int n);
    repeat (n) tok_buf.push_back(rand_digit());
  endfunction

  function automatic void gen_good(input class_t cls);
    tok_buf.delete();
    case (cls)
      CL_POSINT: add_digits($urandom_range(1, 6));
      CL_NEGINT: begin
        tok_buf.push_back(CH_DASH);
        add_digits($urandom_range(1, 5));
      end
      CL_BINARY: begin
        tok_buf.push_back(CH_ZERO);
        tok_buf.push_back(CH_B);
        repeat ($urandom_range(1, 6)) tok_buf.push_back($urandom_range(1) ? CH_ONE : CH_ZERO);
      end
      CL_GUID: begin
        for (int i = 0; i < GUID_LEN; i++) begin
          if (i == GUID_DASH0 || i == GUID_DASH1 || i == GUID_DASH2 || i == GUID_DASH3)
            tok_buf.push_back(CH_DASH);
          else
            tok_buf.push_back(rand_hex());
        end
      end
      CL_POSFLT, CL_NEGFLT: begin
        if (cls == CL_NEGFLT) tok_buf.push_back(CH_DASH);
        add_digits($urandom_range(1, 4));
        tok_buf.push_back(CH_DOT);
        add_digits($urandom_range(1, 4));
      end
      default: add_digits(1);
    endcase
  endfunction

  function automatic void make_token();
    int pick, idx;
    pick = $urandom_range(99);
    if (pick < 62) begin
      gen_good(class_t'($urandom_range(5)));
    end else if (pick < 80) begin
      // well-formed token with one character changed, dropped or added
      gen_good(class_t'($urandom_range(5)));
      idx = $urandom_range(tok_buf.size() - 1);
      case ($urandom_range(2))
        0: tok_buf[idx] = odd_char();
        1: begin
          if (tok_buf.size() > 1) tok_buf.delete(idx);
          else tok_buf[idx] = odd_char();
        end
        default: tok_buf.insert(idx, odd_char());
      endcase
    end else if (pick < 90) begin
      tok_buf.delete();
      repeat ($urandom_range(1, 6)) tok_buf.push_back(8'($urandom_range(255)));
    end else if (pick < 97) begin
      tok_buf.delete();
      repeat ($urandom_range(1, 4)) tok_buf.push_back(odd_char());
    end else if (pick < 99) begin
      // near-guid: length around 36, dashes mostly in place
      tok_buf.delete();
      for (int i = 0; i < GUID_LEN - 1 + $urandom_range(2); i++) begin
        if (i == GUID_DASH0 || i == GUID_DASH1 || i == GUID_DASH2 || i == GUID_DASH3)
          tok_buf.push_back(($urandom_range(9) < 7) ? CH_DASH : odd_char());
        else
          tok_buf.push_back(($urandom_range(9) < 9) ? rand_hex() : CH_DASH);
      end
    end else begin
      // length straddling the overflow limit
      tok_buf.delete();
      if ($urandom_range(1)) tok_buf.push_back(CH_DASH);
      add_digits(TOK_MAX - 1 + $urandom_range(4));
    end
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fin);
    logic    emit;
    result_t res;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      chars_bus.valid <= 1'b0;
      @(posedge clk);
    end
    chars_bus.valid <= 1'b1;
    chars_bus.ch    <= c;
    chars_bus.last  <= fin;
    do begin
      @(posedge clk);
    end while (!chars_bus.ready);
    token_classify(c, fin, emit, res);
    if (emit) class_q.push_back(typed_on ? typed_res : res);
    chars_sent++;
  endtask

  task automatic send_token();
    for (int i = 0; i < tok_buf.size(); i++) send_char(tok_buf[i], i == tok_buf.size() - 1);
  endtask

  initial begin : class_sink
    bit hold_done;
    hold_done = 1'b0;
    class_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        // long back-pressure so the block fills and stalls its input
        class_bus.ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        hold_done = 1'b1;
      end
      class_bus.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : class_check
    result_t want;
    if (!rst && class_bus.valid && class_bus.ready) begin
      if (class_q.size() == 0) begin
        $display("%0t: class item with none pending: code %0d too_long %0b",
                 $time, class_bus.class_code, class_bus.too_long);
        errs++;
      end else begin
        want = class_q.pop_front();
        if (class_bus.class_code !== want.class_code) begin
          $display("%0t: class_code expected %0d actual %0d",
                   $time, want.class_code, class_bus.class_code);
          errs++;
        end
        if (class_bus.too_long !== want.too_long) begin
          $display("%0t: too_long expected %0b actual %0b",
                   $time, want.too_long, class_bus.too_long);
          errs++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (chars_bus.valid && chars_bus.ready) || (class_bus.valid && class_bus.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stim
    rst             <= 1'b1;
    chars_bus.valid <= 1'b0;
    chars_bus.ch    <= '0;
    chars_bus.last  <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[r]) begin
      tok_buf.delete();
      for (int i = 0; i < dir_tab[r].text.len(); i++) tok_buf.push_back(dir_tab[r].text[i]);
      repeat (dir_tab[r].fill_n) tok_buf.push_back(dir_tab[r].fill_ch);
      typed_on = dir_tab[r].typed;
      typed_res.class_code = dir_tab[r].code;
      typed_res.too_long = dir_tab[r].too_long;
      send_token();
    end
    typed_on = 1'b0;

    chars_sent = 0;
    while (chars_sent < RAND_CHARS) begin
      quiet <= (chars_sent >= QUIET_FROM) && (chars_sent < QUIET_TO);
      if (chars_sent >= HOLD_AT) hold_go <= 1'b1;
      make_token();
      send_token();
    end
    quiet <= 1'b0;
    chars_bus.valid <= 1'b0;

    while (class_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errs == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
